>>> rtl/pgbt_pkg.sv
// Package: shared constants, request/response types and controller/datapath links.
package pgbt_pkg;

    localparam int DEGREE_BOUND     = 64;
    localparam int MD_W             = 7;
    localparam int GAIN_W           = 8;
    localparam int IDX_W            = 8;
    localparam int NUM_VERTICES     = 1024;
    localparam int VID_W            = 10;
    localparam int BUCKETS_PER_SIDE = 2 * DEGREE_BOUND + 1;
    localparam int NUM_BUCKETS      = 2 * BUCKETS_PER_SIDE;
    localparam int BADDR_W          = $clog2(NUM_BUCKETS);
    localparam int CNT_W            = 11;
    localparam int MAX_DEGREE_RESET = 64;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_INC    = 2'd1;
    localparam logic [1:0] CMD_DEC    = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [VID_W-1:0]        vertex_id;
        logic                    side_left;
        logic signed [GAIN_W-1:0] initial_gain;
    } req_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] vertex_gain_now;
        logic [IDX_W-1:0]         left_max_index;
        logic [IDX_W-1:0]         right_max_index;
        logic                     range_error;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic               capture;
        logic               bkt_rd;
        logic               upd;
        logic               wr2;
        logic               clr;
        logic [BADDR_W-1:0] clr_addr;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic move;
    } sts_t;

endpackage

>>> rtl/partition_gain_bucket_table_core.sv
// Top level: gain-bucket table for two-way partitioning, controller plus datapath.
//
//  channel   signals                  direction  handshake
//  request   start, busy, req         in         taken when start && !busy
//  response  done, rsp                out        one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_data         in         max_degree written when cfg_we
//
// Insert, refused and unused commands pass through capture/gain read, bucket read and
// update; increment and decrement add a second write on the single bucket-memory
// write port. done rises the cycle after the update.
// After reset all 258 bucket counts are cleared, one entry a cycle, with busy high;
// config writes are taken meanwhile. The receiver cannot stall.
module partition_gain_bucket_table_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pgbt_pkg::req_t                req,
    output logic                          done,
    output pgbt_pkg::rsp_t                rsp,
    input  logic                          cfg_we,
    input  logic [pgbt_pkg::MD_W-1:0]     cfg_data
);

    pgbt_pkg::ctl_t ctl;
    pgbt_pkg::sts_t sts;

    pgbt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl),
        .sts   (sts)
    );

    pgbt_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req),
        .ctl      (ctl),
        .sts      (sts),
        .rsp      (rsp)
    );

endmodule

>>> rtl/pgbt_ctrl.sv
// Controller: bucket clearing sweep and per-request sequencing.
module pgbt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output pgbt_pkg::ctl_t    ctl,
    input  pgbt_pkg::sts_t    sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_GAIN,
        S_UPD,
        S_WR2
    } state_t;

    state_t                        state_reg, state_next;
    logic [pgbt_pkg::BADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic                          done_reg, done_next;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        done_next    = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == pgbt_pkg::BADDR_W'(pgbt_pkg::NUM_BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_GAIN;
                end
            end
            S_GAIN:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                done_next  = 1'b1;
                state_next = sts.move ? S_WR2 : S_IDLE;
            end
            S_WR2:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign ctl.capture  = (state_reg == S_IDLE) && start;
    assign ctl.bkt_rd   = (state_reg == S_GAIN);
    assign ctl.upd      = (state_reg == S_UPD);
    assign ctl.wr2      = (state_reg == S_WR2);
    assign ctl.clr      = (state_reg == S_CLEAR);
    assign ctl.clr_addr = clr_cnt_reg;

`ifndef SYNTHESIS
    a_done_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_UPD))
        else $error("done without update cycle");
    a_wr2_after_move: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR2) |-> $past(state_reg == S_UPD) && $past(sts.move))
        else $error("second write without move");
    a_clear_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) && (state_next != S_CLEAR) |=> !busy)
        else $error("clear sweep did not end in idle");
`endif

endmodule

>>> rtl/pgbt_datapath.sv
// Datapath: vertex gain memory, bucket count memory, range checks and top indices.
module pgbt_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pgbt_pkg::MD_W-1:0]         cfg_data,
    input  pgbt_pkg::req_t                    req,
    input  pgbt_pkg::ctl_t                    ctl,
    output pgbt_pkg::sts_t                    sts,
    output pgbt_pkg::rsp_t                    rsp
);

    localparam int GW = pgbt_pkg::GAIN_W;
    localparam int EW = GW + 2;
    localparam int AW = pgbt_pkg::BADDR_W;
    localparam int CW = pgbt_pkg::CNT_W;
    localparam int IW = pgbt_pkg::IDX_W;

    logic [GW-1:0] gain_mem [pgbt_pkg::NUM_VERTICES];
    logic [CW-1:0] bkt_mem  [pgbt_pkg::NUM_BUCKETS];

    logic [pgbt_pkg::MD_W-1:0] max_degree_reg;
    pgbt_pkg::req_t            req_reg;
    logic [GW-1:0]             gain_rd_reg;
    logic [CW-1:0]             old_cnt_reg, new_cnt_reg;
    logic                      act_reg, move_reg;
    logic                      err_reg;
    logic [GW-1:0]             gnew_reg, gout_reg;
    logic [IW-1:0]             old_idx_reg, new_idx_reg;
    logic [AW-1:0]             old_addr_reg, new_addr_reg;
    logic [IW-1:0]             left_top_reg, right_top_reg;
    logic [IW-1:0]             left_top_next, right_top_next;
    pgbt_pkg::rsp_t            rsp_reg;

    logic [pgbt_pkg::MD_W-1:0] md;
    logic [GW-1:0]             g_src;
    logic signed [EW-1:0]      g_ext, md_ext, g_new, sum_old, sum_new;
    logic                      in_rng, bad, act;
    logic [IW-1:0]             old_idx, new_idx;
    logic [AW-1:0]             old_addr, new_addr;
    logic [IW-1:0]             top_sel, top_upd;
    logic                      bkt_we;
    logic [AW-1:0]             bkt_waddr;
    logic [CW-1:0]             bkt_wdata;

    function automatic logic [AW-1:0] slot_addr(input logic left, input logic [IW-1:0] idx);
        logic [AW-1:0] a;
        a = AW'(idx);
        return left ? a : a + AW'(pgbt_pkg::BUCKETS_PER_SIDE);
    endfunction

    assign md = (max_degree_reg > pgbt_pkg::MD_W'(pgbt_pkg::DEGREE_BOUND))
                ? pgbt_pkg::MD_W'(pgbt_pkg::DEGREE_BOUND) : max_degree_reg;

    // gain checks, evaluated while the stored gain sits in gain_rd_reg
    always_comb
    begin
        g_src  = (req_reg.cmd == pgbt_pkg::CMD_INSERT) ? req_reg.initial_gain : gain_rd_reg;
        g_ext  = $signed({{2{g_src[GW-1]}}, g_src});
        md_ext = $signed({{(EW-pgbt_pkg::MD_W){1'b0}}, md});
        in_rng = (g_ext >= -md_ext) && (g_ext <= md_ext);
        case (req_reg.cmd)
            pgbt_pkg::CMD_INSERT:
            begin
                g_new = g_ext;
                bad   = !in_rng;
            end
            pgbt_pkg::CMD_INC:
            begin
                g_new = g_ext + EW'(2);
                bad   = !in_rng || (g_new > md_ext);
            end
            pgbt_pkg::CMD_DEC:
            begin
                g_new = g_ext - EW'(2);
                bad   = !in_rng || (g_new < -md_ext);
            end
            default:
            begin
                g_new = g_ext;
                bad   = 1'b0;
            end
        endcase
        act      = !bad && (req_reg.cmd != pgbt_pkg::CMD_NOP);
        sum_old  = md_ext + g_ext;
        sum_new  = md_ext + g_new;
        old_idx  = sum_old[IW-1:0];
        new_idx  = sum_new[IW-1:0];
        old_addr = slot_addr(req_reg.side_left, old_idx);
        new_addr = slot_addr(req_reg.side_left, new_idx);
    end

    // top index update; decrement lowers it only when its old bucket empties
    always_comb
    begin
        top_sel = req_reg.side_left ? left_top_reg : right_top_reg;
        top_upd = top_sel;
        if (act_reg)
        begin
            if (req_reg.cmd == pgbt_pkg::CMD_DEC)
            begin
                if ((old_cnt_reg <= CW'(1)) && (top_sel == old_idx_reg))
                begin
                    top_upd = top_sel - 1'b1;
                end
            end
            else if (new_idx_reg > top_sel)
            begin
                top_upd = new_idx_reg;
            end
        end
        left_top_next  = (ctl.upd && req_reg.side_left)  ? top_upd : left_top_reg;
        right_top_next = (ctl.upd && !req_reg.side_left) ? top_upd : right_top_reg;
    end

    // single bucket write port: clear sweep, first update write, second write
    always_comb
    begin
        bkt_we    = 1'b0;
        bkt_waddr = new_addr_reg;
        bkt_wdata = (new_cnt_reg == {CW{1'b1}}) ? new_cnt_reg : new_cnt_reg + 1'b1;
        if (ctl.clr)
        begin
            bkt_we    = 1'b1;
            bkt_waddr = ctl.clr_addr;
            bkt_wdata = '0;
        end
        else if (ctl.upd && act_reg)
        begin
            bkt_we = 1'b1;
            if (move_reg)
            begin
                bkt_waddr = old_addr_reg;
                bkt_wdata = (old_cnt_reg == '0) ? old_cnt_reg : old_cnt_reg - 1'b1;
            end
        end
        else if (ctl.wr2)
        begin
            bkt_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            gain_rd_reg <= gain_mem[req.vertex_id];
        end
        if (ctl.upd && act_reg)
        begin
            gain_mem[req_reg.vertex_id] <= gnew_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.bkt_rd)
        begin
            old_cnt_reg <= bkt_mem[old_addr];
            new_cnt_reg <= bkt_mem[new_addr];
        end
        if (bkt_we)
        begin
            bkt_mem[bkt_waddr] <= bkt_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            req_reg <= req;
        end
        if (ctl.bkt_rd)
        begin
            err_reg      <= bad;
            gnew_reg     <= g_new[GW-1:0];
            gout_reg     <= bad ? gain_rd_reg : g_new[GW-1:0];
            old_idx_reg  <= old_idx;
            new_idx_reg  <= new_idx;
            old_addr_reg <= old_addr;
            new_addr_reg <= new_addr;
        end
        if (ctl.upd)
        begin
            rsp_reg.vertex_gain_now <= gout_reg;
            rsp_reg.left_max_index  <= left_top_next;
            rsp_reg.right_max_index <= right_top_next;
            rsp_reg.range_error     <= err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_degree_reg <= pgbt_pkg::MD_W'(pgbt_pkg::MAX_DEGREE_RESET);
            act_reg        <= 1'b0;
            move_reg       <= 1'b0;
            left_top_reg   <= '0;
            right_top_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_degree_reg <= cfg_data;
            end
            if (ctl.bkt_rd)
            begin
                act_reg  <= act;
                move_reg <= act && ((req_reg.cmd == pgbt_pkg::CMD_INC) ||
                                    (req_reg.cmd == pgbt_pkg::CMD_DEC));
            end
            left_top_reg  <= left_top_next;
            right_top_reg <= right_top_next;
        end
    end

    assign sts.move = move_reg;
    assign rsp      = rsp_reg;

`ifndef SYNTHESIS
    a_left_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_top_reg <= IW'(2 * pgbt_pkg::DEGREE_BOUND))
        else $error("left top index out of bucket range");
    a_right_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        right_top_reg <= IW'(2 * pgbt_pkg::DEGREE_BOUND))
        else $error("right top index out of bucket range");
    a_bkt_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bkt_we |-> (bkt_waddr < AW'(pgbt_pkg::NUM_BUCKETS)))
        else $error("bucket write beyond table");
    a_top_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.upd |=> $stable(left_top_reg) && $stable(right_top_reg))
        else $error("top index changed outside update");
`endif

endmodule
